[design/tfr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared types and constants of the telemetry frame receiver.
// ----------------------------------------------------------------------------
package tfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 8;

  localparam logic [CfgIdxW-1:0] CfgHeader = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSource = 2'd1;

  localparam logic [ByteW-1:0] HeaderReset = 8'hAA;
  localparam logic [ByteW-1:0] SourceReset = 8'hAF;

  // buffer index of the first payload byte
  localparam logic [PosW-1:0] PayloadBase = 9'd5;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_SOURCE  = 3'd1,
    PH_DEST    = 3'd2,
    PH_FUNC    = 3'd3,
    PH_LENGTH  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_SUM     = 3'd6
  } phase_e;

  typedef struct packed {
    logic            store_en;
    logic [PosW-1:0] buf_position;
    logic            frame_done;
  } res_t;

endpackage
`default_nettype wire

[design/tfr_rx_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_rx_if
// Received byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface tfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

[design/tfr_res_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_res_if
// Result channel: per-byte store flag, buffer position and frame end flag.
// ----------------------------------------------------------------------------
interface tfr_res_if;
  logic       valid;
  logic       ready;
  logic       store_en;
  logic [8:0] buf_position;
  logic       frame_done;

  modport source (output valid, output store_en, output buf_position,
                  output frame_done, input ready);
  modport sink   (input valid, input store_en, input buf_position,
                  input frame_done, output ready);
endinterface
`default_nettype wire

[design/tfr_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_parser
// Frame phase tracker: classifies each accepted byte and advances the phase.
// ----------------------------------------------------------------------------
module tfr_parser
  import tfr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [ByteW-1:0] byte_i,
  input  wire logic [ByteW-1:0] header_i,
  input  wire logic [ByteW-1:0] source_i,
  output res_t                  res_o
);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] left_q, left_d;
  logic [ByteW-1:0] count_q, count_d;
  logic [PosW-1:0]  pay_pos;

  assign pay_pos = PayloadBase + PosW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      left_q  <= '0;
      count_q <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    count_d = count_q;
    res_o   = '0;
    case (phase_q)
      PH_HEADER: begin
        if (byte_i == header_i) begin
          res_o.store_en = 1'b1;
          phase_d        = PH_SOURCE;
        end
      end
      PH_SOURCE: begin
        // a mismatch drops the byte, even a header value
        if (byte_i == source_i) begin
          res_o.store_en     = 1'b1;
          res_o.buf_position = PosW'(1);
          phase_d            = PH_DEST;
        end else begin
          phase_d = PH_HEADER;
        end
      end
      PH_DEST: begin
        res_o.store_en     = 1'b1;
        res_o.buf_position = PosW'(2);
        phase_d            = PH_FUNC;
      end
      PH_FUNC: begin
        res_o.store_en     = 1'b1;
        res_o.buf_position = PosW'(3);
        phase_d            = PH_LENGTH;
      end
      PH_LENGTH: begin
        res_o.store_en     = 1'b1;
        res_o.buf_position = PosW'(4);
        left_d             = byte_i;
        count_d            = '0;
        phase_d            = (byte_i == '0) ? PH_SUM : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (left_q != '0) begin
          res_o.store_en     = 1'b1;
          res_o.buf_position = pay_pos;
          count_d            = count_q + ByteW'(1);
          left_d             = left_q - ByteW'(1);
          if (left_q == ByteW'(1)) begin
            phase_d = PH_SUM;
          end
        end else begin
          phase_d = PH_HEADER;
        end
      end
      PH_SUM: begin
        res_o.store_en     = 1'b1;
        res_o.frame_done   = 1'b1;
        res_o.buf_position = pay_pos;
        phase_d            = PH_HEADER;
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase
  end

endmodule
`default_nettype wire

[design/tfr_out_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_out_stage
// Result register: holds one result until the sink takes the transaction.
// ----------------------------------------------------------------------------
module tfr_out_stage
  import tfr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  load_i,
  input  wire res_t  res_i,
  output logic       free_o,
  tfr_res_if.source  res_o
);

  logic valid_q;
  res_t data_q;

  // the register frees up in the same cycle its content is taken
  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.store_en     = data_q.store_en;
  assign res_o.buf_position = data_q.buf_position;
  assign res_o.frame_done   = data_q.frame_done;

endmodule
`default_nettype wire

[design/telemetry_frame_receiver.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// telemetry_frame_receiver
// Byte-wise parser for header/source/dest/function/length/payload/sum frames.
// ----------------------------------------------------------------------------
// Each accepted byte gives exactly one registered result in the next cycle:
// store_en says whether the byte belongs to a frame, buf_position its buffer
// index (0..260) and frame_done marks the trailing sum byte, which is not
// checked. One byte is taken every cycle unless stalled; the only storage
// between the sides is the result register, so rx ready follows res ready
// while a result is waiting. The header and source values are written
// through the cfg port (index 0 and 1) and apply from the next byte on.
module telemetry_frame_receiver
  import tfr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  tfr_rx_if.sink                  rx_i,
  tfr_res_if.source               res_o
);

  logic [ByteW-1:0] header_q;
  logic [ByteW-1:0] source_q;
  logic             free;
  logic             take;
  res_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
      source_q <= SourceReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHeader: header_q <= cfg_wdata_i;
        CfgSource: source_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign rx_i.ready = free;
  assign take       = rx_i.valid && free;

  tfr_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .byte_i   (rx_i.rx_byte),
    .header_i (header_q),
    .source_i (source_q),
    .res_o    (res)
  );

  tfr_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (take),
    .res_i  (res),
    .free_o (free),
    .res_o  (res_o)
  );

endmodule
`default_nettype wire

[tb/tfr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_checker
// Watches the byte and result channels of the frame receiver, works out the
// result that each accepted byte should give and compares it field by field.
// ----------------------------------------------------------------------------
module tfr_checker
  import tfr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  input  wire logic               rx_valid_i,
  input  wire logic               rx_ready_i,
  input  wire logic [ByteW-1:0]   rx_byte_i,
  input  wire logic               res_valid_i,
  input  wire logic               res_ready_i,
  input  wire logic               res_store_en_i,
  input  wire logic [PosW-1:0]    res_buf_position_i,
  input  wire logic               res_frame_done_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);

  logic [ByteW-1:0] header_value;
  logic [ByteW-1:0] source_value;
  phase_e           phase;
  logic [ByteW-1:0] bytes_left;
  logic [ByteW-1:0] payload_count;
  res_t             expected_results[$];

  function automatic res_t parse_byte(input logic [ByteW-1:0] b);
    res_t r;
    r = '0;
    case (phase)
      PH_HEADER: begin
        if (b == header_value) begin
          r.store_en     = 1'b1;
          r.buf_position = 9'd0;
          phase          = PH_SOURCE;
        end
      end
      PH_SOURCE: begin
        // a wrong source byte is dropped, even when it looks like a header
        if (b == source_value) begin
          r.store_en     = 1'b1;
          r.buf_position = 9'd1;
          phase          = PH_DEST;
        end else begin
          phase = PH_HEADER;
        end
      end
      PH_DEST: begin
        r.store_en     = 1'b1;
        r.buf_position = 9'd2;
        phase          = PH_FUNC;
      end
      PH_FUNC: begin
        r.store_en     = 1'b1;
        r.buf_position = 9'd3;
        phase          = PH_LENGTH;
      end
      PH_LENGTH: begin
        r.store_en     = 1'b1;
        r.buf_position = 9'd4;
        bytes_left     = b;
        payload_count  = '0;
        phase          = (b == '0) ? PH_SUM : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (bytes_left != '0) begin
          r.store_en     = 1'b1;
          r.buf_position = PayloadBase + {1'b0, payload_count};
          payload_count  = payload_count + 8'd1;
          bytes_left     = bytes_left - 8'd1;
          if (bytes_left == '0) begin
            phase = PH_SUM;
          end
        end else begin
          phase = PH_HEADER;
        end
      end
      PH_SUM: begin
        r.store_en     = 1'b1;
        r.frame_done   = 1'b1;
        r.buf_position = PayloadBase + {1'b0, payload_count};
        phase          = PH_HEADER;
      end
      default: begin
        phase = PH_HEADER;
      end
    endcase
    return r;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  // result check comes before the byte of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      header_value  = HeaderReset;
      source_value  = SourceReset;
      phase         = PH_HEADER;
      bytes_left    = '0;
      payload_count = '0;
      expected_results.delete();
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no byte outstanding: store_en %0d, buf_position %0d",
                 res_store_en_i, res_buf_position_i);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          compare_field("store_en", want.store_en, res_store_en_i);
          compare_field("buf_position", want.buf_position, res_buf_position_i);
          compare_field("frame_done", want.frame_done, res_frame_done_i);
        end
      end
      if (rx_valid_i && rx_ready_i) begin
        expected_results.push_back(parse_byte(rx_byte_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgHeader: header_value = cfg_wdata_i;
          CfgSource: source_value = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o = expected_results.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Frame receiver regression: directed frames, then random well-formed and
// broken frames mixed with line noise under several header/source settings,
// with random stalls on both channels; a checker beside the block compares.
// ----------------------------------------------------------------------------
module testbench;
  import tfr_pkg::*;

  // indexes past the last register are ignored by the block
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  localparam int unsigned IdlePercent   = 23;
  localparam int unsigned HoldOffCycles = 80;

  // waiting noise, zero length frame, wrong source equal to the header,
  // then frames of one and two payload bytes
  localparam logic [ByteW-1:0] DirectedBytes [25] = '{
    8'h00,
    HeaderReset, SourceReset, 8'h00, 8'hFF, 8'h00, 8'hFF,
    HeaderReset, HeaderReset, SourceReset,
    HeaderReset, SourceReset, 8'h12, 8'h34, 8'h01, 8'hFF, 8'h5A,
    HeaderReset, SourceReset, 8'h01, 8'h02, 8'h02, 8'h80, 8'h7F, 8'h00
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;

  tfr_rx_if  rx ();
  tfr_res_if res ();

  int unsigned fail_count;
  int unsigned pending;
  bit          steady;
  int unsigned hold_off_requests;
  int unsigned bytes_sent;
  logic [ByteW-1:0] cur_header;
  logic [ByteW-1:0] cur_source;

  telemetry_frame_receiver i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx),
    .res_o       (res)
  );

  tfr_checker i_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .rx_valid_i         (rx.valid),
    .rx_ready_i         (rx.ready),
    .rx_byte_i          (rx.rx_byte),
    .res_valid_i        (res.valid),
    .res_ready_i        (res.ready),
    .res_store_en_i     (res.store_en),
    .res_buf_position_i (res.buf_position),
    .res_frame_done_i   (res.frame_done),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("telemetry_frame_receiver regression: fail");
    $finish;
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin
    int unsigned hold_off_served;
    int unsigned hold_left;
    hold_off_served = 0;
    hold_left       = 0;
    res.ready       = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_off_served != hold_off_requests) begin
        hold_off_served++;
        hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else begin
        res.ready <= steady || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while (!steady && $urandom_range(99) < IdlePercent) begin
      rx.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk_i);
    while (!rx.ready) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    rx.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_registers(input logic [ByteW-1:0] header, input logic [ByteW-1:0] source);
    drain();
    write_register(CfgHeader, header);
    write_register(CfgSource, source);
    write_register($urandom_range(1) ? CfgSpareA : CfgSpareB, CfgW'($urandom_range(255)));
    cur_header = header;
    cur_source = source;
  endtask

  task automatic send_frame(input logic [ByteW-1:0] len);
    send_byte(cur_header);
    send_byte(cur_source);
    send_byte(ByteW'($urandom_range(255)));
    send_byte(ByteW'($urandom_range(255)));
    send_byte(len);
    repeat (len) send_byte(ByteW'($urandom_range(255)));
    send_byte(ByteW'($urandom_range(255)));
  endtask

  task automatic run_traffic(input int unsigned budget);
    int unsigned      stop_at;
    int unsigned      pick;
    logic [ByteW-1:0] flip;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // line noise between frames
        repeat ($urandom_range(4, 1)) send_byte(ByteW'($urandom_range(255)));
      end else if (pick < 16) begin
        // broken frame: wrong source byte
        flip = ByteW'($urandom_range(255, 1));
        send_byte(cur_header);
        send_byte(cur_source ^ flip);
      end else if (pick < 19) begin
        send_frame(ByteW'($urandom_range(255)));
      end else begin
        send_frame(ByteW'($urandom_range(8)));
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CfgHeader;
    cfg_wdata_i       = '0;
    rx.valid          = 1'b0;
    rx.rx_byte        = '0;
    steady            = 1'b0;
    hold_off_requests = 0;
    bytes_sent        = 0;
    cur_header        = HeaderReset;
    cur_source        = SourceReset;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DirectedBytes[i]) send_byte(DirectedBytes[i]);

    run_traffic(220);
    steady = 1'b1;
    run_traffic(150);
    steady = 1'b0;
    // the block fills up and stalls its byte input
    hold_off_requests++;
    run_traffic(180);
    drain();
    run_traffic(100);

    set_registers(8'h00, 8'hFF);
    run_traffic(220);
    set_registers(8'hFF, 8'h00);
    send_frame(8'hFF);
    run_traffic(160);
    set_registers(8'h55, 8'h55);
    run_traffic(180);
    set_registers(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)));
    run_traffic(200);
    set_registers(HeaderReset, SourceReset);
    run_traffic(100);

    drain();
    repeat (4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("telemetry_frame_receiver regression: pass");
    end else begin
      $display("telemetry_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule
